>>> sv/eqi_pkg.sv
package eqi_pkg;

  localparam int DEF_CORDIC_STEPS  = 16;
  localparam int DEF_FRACTION_BITS = 15;

  localparam int ANGLE_W = 14;
  localparam int RATE_W  = 16;
  localparam int QUAT_W  = 16;
  localparam int OMEGA_W = 17;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 120;

  localparam int HALF_TURN   = 5760;
  localparam int QUARTER     = 2880;
  localparam int QUAT_LIMIT  = 32767;
  localparam int OMEGA_LIMIT = 36600;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint K_Q30  = 64'sd652032874;

  // floor(2^24 / 45): quotient estimate, at most one short
  localparam longint RECIP45   = 64'sd372827;
  localparam int     RECIP_SH  = 24;
  localparam int     DIV_CONST = 45;

  localparam int ATAN_ENTRIES = 24;
  localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

endpackage

>>> sv/eqi_front.sv
module eqi_front #(
  parameter int FRACTION_BITS = eqi_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [eqi_pkg::ANGLE_W-1:0]   up_angle [3],
  input  logic signed [eqi_pkg::RATE_W-1:0]    up_rate  [3],
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [FRACTION_BITS+2:0]      dn_theta [3],
  output logic        [2:0]                    dn_flip,
  output logic signed [eqi_pkg::OMEGA_W-1:0]   dn_omega [3]
);
  import eqi_pkg::*;

  localparam int W  = FRACTION_BITS + 3;
  localparam int NS = 4;
  // half angle: theta = round(|a| * PI_Q30 / (5760 * 2^(30-F))), split as |a|*Q + |a|*R/D
  localparam longint ANG_D = longint'(HALF_TURN) << (30 - FRACTION_BITS);
  localparam longint ANG_Q = PI_Q30 / ANG_D;
  localparam longint ANG_R = PI_Q30 - ANG_Q * ANG_D;
  localparam int     ANG_K = 37 - FRACTION_BITS;
  localparam longint OM_D  = longint'(QUARTER) << 20;
  localparam longint OM_Q  = PI_Q30 / OM_D;
  localparam longint OM_R  = PI_Q30 - OM_Q * OM_D;
  localparam int     OM_K  = 26;

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NS; s++) if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  // stage 1: fold to +-90 degree half angle, take magnitudes
  logic signed [ANGLE_W-1:0] red [3];
  logic [2:0]                flip_nxt;
  logic [11:0]  s1_abs_r [3];
  logic [2:0]   s1_neg_r, s1_flip_r, s1_rneg_r;
  logic [16:0]  s1_rabs_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      flip_nxt[k] = 1'b1;
      if (up_angle[k] > 14'sd2880)       red[k] = up_angle[k] - 14'sd5760;
      else if (up_angle[k] < -14'sd2880) red[k] = up_angle[k] + 14'sd5760;
      else begin
        red[k]      = up_angle[k];
        flip_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        s1_neg_r[k]  <= red[k][ANGLE_W-1];
        s1_abs_r[k]  <= red[k][ANGLE_W-1] ? 12'(-red[k]) : 12'(red[k]);
        s1_flip_r[k] <= flip_nxt[k];
        s1_rneg_r[k] <= up_rate[k][RATE_W-1];
        s1_rabs_r[k] <= up_rate[k][RATE_W-1] ? 17'(-18'(up_rate[k])) : 17'(up_rate[k]);
      end
    end
  end

  // stage 2: multiply by the constant parts
  logic [47:0] ta [3], tr [3];
  logic [16:0] s2_t_r [3];
  logic [W-1:0] s2_aq_r [3];
  logic [17:0] s2_rt_r [3], s2_rq_r [3];
  logic [2:0]  s2_neg_r, s2_flip_r, s2_rneg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ta[k] = 48'(s1_abs_r[k]) * 48'(ANG_R) + 48'(ANG_D / 2);
      tr[k] = 48'(s1_rabs_r[k]) * 48'(OM_R) + 48'(OM_D / 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s2_t_r[k]  <= 17'(ta[k] >> ANG_K);
        s2_aq_r[k] <= W'(48'(s1_abs_r[k]) * 48'(ANG_Q));
        s2_rt_r[k] <= 18'(tr[k] >> OM_K);
        s2_rq_r[k] <= 18'(48'(s1_rabs_r[k]) * 48'(OM_Q));
      end
      s2_neg_r  <= s1_neg_r;
      s2_flip_r <= s1_flip_r;
      s2_rneg_r <= s1_rneg_r;
    end
  end

  // stage 3: divide by 45 through the reciprocal
  logic [39:0] pa [3], pr [3];
  logic [16:0] s3_t_r [3];
  logic [11:0] s3_qe_r [3];
  logic [W-1:0] s3_aq_r [3];
  logic [17:0] s3_rt_r [3], s3_rq_r [3];
  logic [12:0] s3_rqe_r [3];
  logic [2:0]  s3_neg_r, s3_flip_r, s3_rneg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = 40'(s2_t_r[k]) * 40'(RECIP45);
      pr[k] = 40'(s2_rt_r[k]) * 40'(RECIP45);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s3_qe_r[k]  <= 12'(pa[k] >> RECIP_SH);
        s3_rqe_r[k] <= 13'(pr[k] >> RECIP_SH);
      end
      s3_t_r    <= s2_t_r;
      s3_aq_r   <= s2_aq_r;
      s3_rt_r   <= s2_rt_r;
      s3_rq_r   <= s2_rq_r;
      s3_neg_r  <= s2_neg_r;
      s3_flip_r <= s2_flip_r;
      s3_rneg_r <= s2_rneg_r;
    end
  end

  // stage 4: quotient correction, sign, omega limit
  logic [18:0]  rem_a [3], rem_r [3];
  logic [W-1:0] mag_a [3];
  logic [17:0]  mag_r [3];
  logic [16:0]  lim_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_a[k] = 19'(s3_t_r[k]) - 19'(s3_qe_r[k]) * 19'(DIV_CONST);
      mag_a[k] = s3_aq_r[k] + W'(s3_qe_r[k]) + W'(rem_a[k] >= 19'(DIV_CONST));
      rem_r[k] = 19'(s3_rt_r[k]) - 19'(s3_rqe_r[k]) * 19'(DIV_CONST);
      mag_r[k] = s3_rq_r[k] + 18'(s3_rqe_r[k]) + 18'(rem_r[k] >= 19'(DIV_CONST));
      lim_r[k] = (mag_r[k] > 18'(OMEGA_LIMIT)) ? 17'(OMEGA_LIMIT) : 17'(mag_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        dn_theta[k] <= s3_neg_r[k] ? -$signed(mag_a[k]) : $signed(mag_a[k]);
        dn_omega[k] <= s3_rneg_r[k] ? -$signed(lim_r[k]) : $signed(lim_r[k]);
      end
      dn_flip <= s3_flip_r;
    end
  end

endmodule

>>> sv/eqi_cordic.sv
module eqi_cordic #(
  parameter int CORDIC_STEPS  = eqi_pkg::DEF_CORDIC_STEPS,
  parameter int FRACTION_BITS = eqi_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [FRACTION_BITS+2:0]      up_theta [3],
  input  logic        [2:0]                    up_flip,
  input  logic signed [eqi_pkg::OMEGA_W-1:0]   up_omega [3],
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [FRACTION_BITS+2:0]      dn_cos [3],
  output logic signed [FRACTION_BITS+2:0]      dn_sin [3],
  output logic signed [eqi_pkg::OMEGA_W-1:0]   dn_omega [3]
);
  import eqi_pkg::*;

  localparam int W  = FRACTION_BITS + 3;
  localparam int NS = CORDIC_STEPS + 1;
  localparam logic signed [W-1:0] X0 = W'(K_Q30 >>> (30 - FRACTION_BITS));

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NS; s++) if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  logic signed [W-1:0]       x_r [CORDIC_STEPS][3];
  logic signed [W-1:0]       y_r [CORDIC_STEPS][3];
  logic signed [W-1:0]       z_r [CORDIC_STEPS][3];
  logic        [2:0]         f_r [CORDIC_STEPS];
  logic signed [OMEGA_W-1:0] o_r [CORDIC_STEPS][3];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [W-1:0] AT = W'(ATAN_Q30[i] >>> (30 - FRACTION_BITS));
    logic signed [W-1:0]       xi [3], yi [3], zi [3];
    logic [2:0]                fi;
    logic signed [OMEGA_W-1:0] oi [3];

    if (i == 0) begin : g_head
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          xi[k] = X0;
          yi[k] = '0;
          zi[k] = up_theta[k];
          oi[k] = up_omega[k];
        end
        fi = up_flip;
      end
    end else begin : g_body
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          xi[k] = x_r[i-1][k];
          yi[k] = y_r[i-1][k];
          zi[k] = z_r[i-1][k];
          oi[k] = o_r[i-1][k];
        end
        fi = f_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        for (int k = 0; k < 3; k++) begin
          if (!zi[k][W-1]) begin
            x_r[i][k] <= xi[k] - (yi[k] >>> i);
            y_r[i][k] <= yi[k] + (xi[k] >>> i);
            z_r[i][k] <= zi[k] - AT;
          end else begin
            x_r[i][k] <= xi[k] + (yi[k] >>> i);
            y_r[i][k] <= yi[k] - (xi[k] >>> i);
            z_r[i][k] <= zi[k] + AT;
          end
          o_r[i][k] <= oi[k];
        end
        f_r[i] <= fi;
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int k = 0; k < 3; k++) begin
        dn_cos[k]   <= f_r[CORDIC_STEPS-1][k] ? -x_r[CORDIC_STEPS-1][k]
                                              : x_r[CORDIC_STEPS-1][k];
        dn_sin[k]   <= f_r[CORDIC_STEPS-1][k] ? -y_r[CORDIC_STEPS-1][k]
                                              : y_r[CORDIC_STEPS-1][k];
        dn_omega[k] <= o_r[CORDIC_STEPS-1][k];
      end
    end
  end

endmodule

>>> sv/eqi_quat.sv
module eqi_quat #(
  parameter int FRACTION_BITS = eqi_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [FRACTION_BITS+2:0]      up_cos [3],
  input  logic signed [FRACTION_BITS+2:0]      up_sin [3],
  input  logic signed [eqi_pkg::OMEGA_W-1:0]   up_omega [3],
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [eqi_pkg::QUAT_W-1:0]    dn_quat [4],
  output logic signed [eqi_pkg::OMEGA_W-1:0]   dn_omega [3]
);
  import eqi_pkg::*;

  localparam int W  = FRACTION_BITS + 3;
  localparam int SW = W + 17;
  localparam int NS = 3;
  localparam logic signed [2*W-1:0] RND = (2*W)'(longint'(1) << (FRACTION_BITS - 1));

  // angle order: yaw, roll, pitch
  localparam int YAW = 0;
  localparam int ROL = 1;
  localparam int PIT = 2;

  function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b);
    p = p + RND;
    return W'(p >>> FRACTION_BITS);
  endfunction

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NS; s++) if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];

  // stage 1: roll x pitch products
  logic signed [W-1:0] cc_r, ss_r, sc_r, cs_r, cy1_r, sy1_r;
  logic signed [OMEGA_W-1:0] o1_r [3], o2_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cc_r  <= mulq(up_cos[ROL], up_cos[PIT]);
      ss_r  <= mulq(up_sin[ROL], up_sin[PIT]);
      sc_r  <= mulq(up_sin[ROL], up_cos[PIT]);
      cs_r  <= mulq(up_cos[ROL], up_sin[PIT]);
      cy1_r <= up_cos[YAW];
      sy1_r <= up_sin[YAW];
      o1_r  <= up_omega;
    end
  end

  // stage 2: times yaw terms
  logic signed [W-1:0] t_r [8];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r[0] <= mulq(cc_r, cy1_r);
      t_r[1] <= mulq(ss_r, sy1_r);
      t_r[2] <= mulq(sc_r, cy1_r);
      t_r[3] <= mulq(cs_r, sy1_r);
      t_r[4] <= mulq(cs_r, cy1_r);
      t_r[5] <= mulq(sc_r, sy1_r);
      t_r[6] <= mulq(cc_r, sy1_r);
      t_r[7] <= mulq(ss_r, cy1_r);
      o2_r   <= o1_r;
    end
  end

  // stage 3: combine, rescale to Q1.15, limit
  logic signed [SW-1:0] sum [4], q15 [4];

  always_comb begin
    sum[0] = SW'(t_r[0]) + SW'(t_r[1]);
    sum[1] = SW'(t_r[2]) - SW'(t_r[3]);
    sum[2] = SW'(t_r[4]) + SW'(t_r[5]);
    sum[3] = SW'(t_r[6]) - SW'(t_r[7]);
  end

  if (FRACTION_BITS > 15) begin : g_down
    localparam logic signed [SW-1:0] RQ = SW'(longint'(1) << (FRACTION_BITS - 16));
    always_comb for (int k = 0; k < 4; k++) q15[k] = (sum[k] + RQ) >>> (FRACTION_BITS - 15);
  end else if (FRACTION_BITS == 15) begin : g_same
    always_comb for (int k = 0; k < 4; k++) q15[k] = sum[k];
  end else begin : g_up
    always_comb for (int k = 0; k < 4; k++) q15[k] = sum[k] <<< (15 - FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 4; k++) begin
        if (q15[k] > SW'(QUAT_LIMIT))       dn_quat[k] <= QUAT_W'(QUAT_LIMIT);
        else if (q15[k] < -SW'(QUAT_LIMIT)) dn_quat[k] <= -QUAT_W'(QUAT_LIMIT);
        else                                dn_quat[k] <= QUAT_W'(q15[k]);
      end
      dn_omega <= o2_r;
    end
  end

endmodule

>>> sv/euler_to_quaternion_imu.sv
// channel | dir | handshake                 | tdata fields, lowest bit first
// in_     | in  | in_tvalid / in_tready     | yaw_angle, roll_angle, pitch_angle (14 each),
//         |     |                           | rate_x_in, rate_y_in, rate_z_in (16 each)
// out_    | out | out_tvalid / out_tready   | quat_w, quat_x, quat_y, quat_z (16 each),
//         |     |                           | omega_x, omega_y, omega_z (17 each)
//
// One beat per cycle sustained while out_tready holds high. The pipeline is the
// 4-stage angle scaling front, one CORDIC stage per iteration plus a sign stage,
// and 3 stages of quaternion products.
// rst_n (synchronous, low) clears the valid bits only.
// Each stage holds while full and blocked; bubbles close up under a stall.
module euler_to_quaternion_imu #(
  parameter int CORDIC_STEPS  = eqi_pkg::DEF_CORDIC_STEPS,
  parameter int FRACTION_BITS = eqi_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // yaw_angle, roll_angle, pitch_angle, rate_x_in, rate_y_in, rate_z_in, pad
  input  logic [eqi_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // quat_w, quat_x, quat_y, quat_z, omega_x, omega_y, omega_z, pad
  output logic [eqi_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import eqi_pkg::*;

  localparam int W = FRACTION_BITS + 3;

  logic signed [ANGLE_W-1:0] angle [3];
  logic signed [RATE_W-1:0]  rate  [3];

  assign angle[0] = in_tdata[13:0];
  assign angle[1] = in_tdata[27:14];
  assign angle[2] = in_tdata[41:28];
  assign rate[0]  = in_tdata[57:42];
  assign rate[1]  = in_tdata[73:58];
  assign rate[2]  = in_tdata[89:74];

  logic                      f_valid, f_ready;
  logic signed [W-1:0]       f_theta [3];
  logic [2:0]                f_flip;
  logic signed [OMEGA_W-1:0] f_omega [3];

  eqi_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst_n,
    .up_valid (in_tvalid), .up_ready (in_tready),
    .up_angle (angle),     .up_rate  (rate),
    .dn_valid (f_valid),   .dn_ready (f_ready),
    .dn_theta (f_theta),   .dn_flip  (f_flip), .dn_omega (f_omega)
  );

  logic                      c_valid, c_ready;
  logic signed [W-1:0]       c_cos [3], c_sin [3];
  logic signed [OMEGA_W-1:0] c_omega [3];

  eqi_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FRACTION_BITS)) u_cordic (
    .clk, .rst_n,
    .up_valid (f_valid), .up_ready (f_ready),
    .up_theta (f_theta), .up_flip  (f_flip), .up_omega (f_omega),
    .dn_valid (c_valid), .dn_ready (c_ready),
    .dn_cos   (c_cos),   .dn_sin   (c_sin),  .dn_omega (c_omega)
  );

  logic signed [QUAT_W-1:0]  q_quat [4];
  logic signed [OMEGA_W-1:0] q_omega [3];

  eqi_quat #(.FRACTION_BITS(FRACTION_BITS)) u_quat (
    .clk, .rst_n,
    .up_valid (c_valid),    .up_ready (c_ready),
    .up_cos   (c_cos),      .up_sin   (c_sin), .up_omega (c_omega),
    .dn_valid (out_tvalid), .dn_ready (out_tready),
    .dn_quat  (q_quat),     .dn_omega (q_omega)
  );

  assign out_tdata = {5'd0, q_omega[2], q_omega[1], q_omega[0],
                      q_quat[3], q_quat[2], q_quat[1], q_quat[0]};

endmodule

>>> sv/eqi_checker.sv
module eqi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [eqi_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import eqi_pkg::*;

  logic signed [OMEGA_W-1:0] om [3];
  logic                      om_ok, q_ok;

  assign om[0] = out_tdata[80:64];
  assign om[1] = out_tdata[97:81];
  assign om[2] = out_tdata[114:98];
  assign om_ok = (om[0] <= 17'sd36600) && (om[0] >= -17'sd36600) &&
                 (om[1] <= 17'sd36600) && (om[1] >= -17'sd36600) &&
                 (om[2] <= 17'sd36600) && (om[2] >= -17'sd36600);
  assign q_ok  = (out_tdata[15:0] != 16'h8000) && (out_tdata[31:16] != 16'h8000) &&
                 (out_tdata[47:32] != 16'h8000) && (out_tdata[63:48] != 16'h8000);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_quat: assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> q_ok)
    else $error("quaternion component beyond limit");

  a_omega: assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> om_ok)
    else $error("omega beyond limit");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output stage");

endmodule

bind euler_to_quaternion_imu eqi_checker u_eqi_checker (.*);
